// ----- design/bsec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsec_pkg
// shared types and constants of the bucketed sliding event counter
// ----------------------------------------------------------------------------
package bsec_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int MIN_WINDOW       = 10;
    localparam int EMIT_PAGES       = 60;

    localparam int WIN_W   = 7;
    localparam int PAGES_W = 16;
    localparam int SECS_W  = 32;
    localparam int SUM_W   = 32;
    localparam int SINCE_W = 17;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(MIN_WINDOW);

    typedef enum logic
    {
        REQ_TRADE = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_t;

    typedef struct packed
    {
        logic             start;
        logic [SUM_W-1:0] open_count;
    } tick_cmd_t;

    typedef struct packed
    {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] sum;
    } ring_stat_t;

endpackage

// ----- design/bsec_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsec_req_if
// input channel: trade and tick items with valid/ready handshake
// ----------------------------------------------------------------------------
interface bsec_req_if;
    import bsec_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [PAGES_W-1:0] pages_to_add;
    logic [SECS_W-1:0]  time_seconds;

    modport source (output valid, output req_type, output pages_to_add,
                    output time_seconds, input ready);
    modport sink   (input valid, input req_type, input pages_to_add,
                    input time_seconds, output ready);
endinterface

// ----- design/bsec_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsec_res_if
// result channel: window sum items with valid/ready handshake
// ----------------------------------------------------------------------------
interface bsec_res_if;
    import bsec_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] window_sum;

    modport source (output valid, output window_sum, input ready);
    modport sink   (input valid, input window_sum, output ready);
endinterface

// ----- design/bsec_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsec_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bsec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bsec_ring_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsec_ring_ctrl
// bucket ring sequencer: inserts empty buckets, evicts old ones, closes the
// open bucket and keeps the running sum
// ----------------------------------------------------------------------------
module bsec_ring_ctrl #(
    parameter int WINDOW_DEPTH = bsec_pkg::WINDOW_DEPTH_DEF,
    localparam int AW = $clog2(WINDOW_DEPTH),
    localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsec_pkg::tick_cmd_t  cmd,
    input  logic [CW-1:0]        zeros,
    input  logic [CW-1:0]        win,
    output bsec_pkg::ring_stat_t stat,
    output logic [CW-1:0]        fill
);
    import bsec_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_ZERO,
        S_ZDROP,
        S_TRIM,
        S_TDROP
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0] open_reg, open_next;
    logic [CW-1:0]    zcnt_reg, zcnt_next;
    logic [CW-1:0]    win_reg, win_next;
    logic             done_reg, done_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SUM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [SUM_W-1:0] ram_rdata;

    logic [CW:0]      tail_sum;
    logic [AW-1:0]    tail;
    logic [AW-1:0]    head_inc;
    logic             full_for_zero;

    bsec_ram #(
        .WIDTH (SUM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // tail slot and head advance, both modulo the ring depth
    always_comb
    begin
        tail_sum = (CW+1)'(head_reg) + (CW+1)'(fill_reg);
        if (tail_sum >= (CW+1)'(WINDOW_DEPTH))
        begin
            tail = AW'(tail_sum - (CW+1)'(WINDOW_DEPTH));
        end
        else
        begin
            tail = AW'(tail_sum);
        end
        head_inc      = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        full_for_zero = ((CW+1)'(fill_reg) + 1'b1) >= (CW+1)'(win_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        open_next  = open_reg;
        zcnt_next  = zcnt_reg;
        win_next   = win_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = tail;
        ram_wdata  = '0;
        ram_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    zcnt_next  = zeros;
                    win_next   = win;
                    open_next  = cmd.open_count;
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (zcnt_reg == '0)
                begin
                    state_next = S_TRIM;
                end
                else if (full_for_zero)
                begin
                    ram_re     = 1'b1;
                    state_next = S_ZDROP;
                end
                else
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    zcnt_next = zcnt_reg - 1'b1;
                end
            end
            S_ZDROP:
            begin
                // evict oldest and append an empty bucket, fill unchanged
                sum_next   = sum_reg - ram_rdata;
                head_next  = head_inc;
                ram_we     = 1'b1;
                zcnt_next  = zcnt_reg - 1'b1;
                state_next = S_ZERO;
            end
            S_TRIM:
            begin
                if (fill_reg >= win_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = S_TDROP;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = open_reg;
                    fill_next  = fill_reg + 1'b1;
                    sum_next   = sum_reg + open_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TDROP:
            begin
                sum_next   = sum_reg - ram_rdata;
                head_next  = head_inc;
                fill_next  = fill_reg - 1'b1;
                state_next = S_TRIM;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        open_reg <= open_next;
        zcnt_reg <= zcnt_next;
        win_reg  <= win_next;
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = done_reg;
    assign stat.sum  = sum_reg;
    assign fill      = fill_reg;

endmodule

// ----- design/bucketed_sliding_event_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_sliding_event_count
// event counter over time buckets with a running sum over the recent window
// ----------------------------------------------------------------------------
// req carries items: a trade adds one to the open bucket (saturating), a tick
// closes buckets. Ticks are ignored until the first one on a whole minute.
// res carries the window sum, sent once sixty or more pages have gone by.
// cfg_we / cfg_wdata write window_pages (clamped to 10..WINDOW_DEPTH); the user
// must write it only while the block is idle; the block does not enforce this.
// Trades stream at one item per cycle while no tick or waiting result holds
// req.ready low. A tick holds req.ready low while the ring sequencer walks
// the bucket memory, inserting z empty buckets (at most the window), evicting
// e buckets to make room for them and t more to trim to the window, and longer
// while a due result waits to enter the output register.
// A finished sequence marks the result pending; it is then registered onto res.
// If res stalls, the result waits in the output register and trades still
// flow; a second result waiting blocks req until the first is taken.
// Reset clears all counters and sets the window to 10; the bucket memory is
// not cleared, only entries written since are ever read.
// ----------------------------------------------------------------------------
module bucketed_sliding_event_count #(
    parameter int WINDOW_DEPTH = bsec_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bsec_pkg::WIN_W-1:0]  cfg_wdata,
    bsec_req_if.sink                    req,
    bsec_res_if.source                  res
);
    import bsec_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic [WIN_W-1:0]   win_cfg_reg;
    logic               aligned_reg, aligned_next;
    logic [SUM_W-1:0]   open_reg, open_next;
    logic [SINCE_W-1:0] since_reg, since_next;
    logic               emit_flag_reg, emit_flag_next;
    logic               emit_pending_reg, emit_pending_next;
    logic               out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]   out_sum_reg, out_sum_next;

    tick_cmd_t          cmd;
    ring_stat_t         stat;
    logic [CW-1:0]      ring_fill;
    logic [CW-1:0]      w_eff;
    logic [CW-1:0]      zeros;
    logic [PAGES_W-1:0] pages_m1;
    logic [SINCE_W-1:0] since_sum;
    logic [6:0]         nib_sum;
    logic [4:0]         nib_fold;
    logic               on_minute;
    logic               accept;

    // effective window
    always_comb
    begin
        if (win_cfg_reg < WIN_W'(MIN_WINDOW))
        begin
            w_eff = CW'(MIN_WINDOW);
        end
        else if (32'(win_cfg_reg) > WINDOW_DEPTH)
        begin
            w_eff = CW'(WINDOW_DEPTH);
        end
        else
        begin
            w_eff = CW'(win_cfg_reg);
        end
    end

    // empty buckets for the tick, clamped to the window
    always_comb
    begin
        pages_m1 = req.pages_to_add - 1'b1;
        if (req.pages_to_add == '0)
        begin
            zeros = '0;
        end
        else if (32'(pages_m1) > 32'(w_eff))
        begin
            zeros = w_eff;
        end
        else
        begin
            zeros = CW'(pages_m1);
        end
    end

    // minute check: divisible by 4 and by 15 (nibble sum modulo 15)
    always_comb
    begin
        nib_sum = '0;
        for (int i = 0; i < SECS_W / 4; i++)
        begin
            nib_sum = nib_sum + 7'(req.time_seconds[4*i +: 4]);
        end
        nib_fold  = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
        on_minute = (req.time_seconds[1:0] == 2'b00) &&
                    ((nib_fold == 5'd0) || (nib_fold == 5'd15));
    end

    assign since_sum = since_reg + SINCE_W'(req.pages_to_add);
    assign req.ready = !stat.busy && !stat.done && !emit_pending_reg;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        aligned_next      = aligned_reg;
        open_next         = open_reg;
        since_next        = since_reg;
        emit_flag_next    = emit_flag_reg;
        emit_pending_next = emit_pending_reg;
        out_valid_next    = out_valid_reg;
        out_sum_next      = out_sum_reg;
        cmd.start         = 1'b0;
        cmd.open_count    = open_reg;

        if (accept)
        begin
            if (req.req_type == REQ_TRADE)
            begin
                if (open_reg != '1)
                begin
                    open_next = open_reg + 1'b1;
                end
            end
            else if (aligned_reg || on_minute)
            begin
                aligned_next = 1'b1;
                cmd.start    = 1'b1;
                open_next    = '0;
                if (32'(since_sum) >= EMIT_PAGES)
                begin
                    since_next     = '0;
                    emit_flag_next = 1'b1;
                end
                else
                begin
                    since_next     = since_sum;
                    emit_flag_next = 1'b0;
                end
            end
        end

        if (stat.done && emit_flag_reg)
        begin
            emit_pending_next = 1'b1;
        end

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit_pending_reg && (!out_valid_reg || res.ready))
        begin
            out_valid_next    = 1'b1;
            out_sum_next      = stat.sum;
            emit_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg      <= WINDOW_RESET;
            aligned_reg      <= 1'b0;
            open_reg         <= '0;
            since_reg        <= '0;
            emit_flag_reg    <= 1'b0;
            emit_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_cfg_reg <= cfg_wdata;
            end
            aligned_reg      <= aligned_next;
            open_reg         <= open_next;
            since_reg        <= since_next;
            emit_flag_reg    <= emit_flag_next;
            emit_pending_reg <= emit_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sum_reg <= out_sum_next;
    end

    assign res.valid      = out_valid_reg;
    assign res.window_sum = out_sum_reg;

    bsec_ring_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ring_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .zeros (zeros),
        .win   (w_eff),
        .stat  (stat),
        .fill  (ring_fill)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_fill <= CW'(WINDOW_DEPTH))
        else $error("ring fill beyond depth");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat.busy) |-> $past(req.valid && req.ready && req.req_type == REQ_TICK))
        else $error("sequencer started without a tick");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(emit_pending_reg))
        else $error("result without pending emission");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bucketed sliding event counter
// ----------------------------------------------------------------------------
// A short table of trades and ticks runs first. It covers the ticks ignored
// before the first whole minute, zero and maximum page counts, and the
// extremes of every field. Random phases follow, each under its own window
// setting. The setting is written only while the block is idle and ranges
// over values below, inside and above the legal range. A bucket ring model
// in the bench works out each window sum that the block should send. Results
// are compared in order, and both channels idle and stall at random. One
// long stall of the result channel backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
    import bsec_pkg::*;

    localparam logic [SECS_W-1:0] MINUTE_SECS = 32'd60;
    localparam int PHASE_ITEMS    = 135;
    localparam int SETTLE_CYCLES  = 300;
    localparam int STALL_AFTER    = 400;
    localparam int STALL_CYCLES   = 1500;
    localparam int N_ROWS         = 23;
    localparam int N_PHASES       = 9;

    typedef struct packed
    {
        req_type_t          op;
        logic [PAGES_W-1:0] pages;
        logic [SECS_W-1:0]  secs;
        logic               typed;
        logic               typed_fire;
        logic [SUM_W-1:0]   typed_sum;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [WIN_W-1:0] cfg_wdata;

    bsec_req_if req_ch ();
    bsec_res_if res_ch ();

    bucketed_sliding_event_count i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    // bucket ring model
    logic [SUM_W-1:0]   bucket_mem [WINDOW_DEPTH_DEF];
    logic [5:0]         oldest_idx   = '0;
    logic [6:0]         held_cnt     = '0;
    logic [SUM_W-1:0]   window_total = '0;
    logic [SUM_W-1:0]   open_trades  = '0;
    logic [SINCE_W-1:0] pages_acc    = '0;
    logic               minute_seen  = 1'b0;
    logic [WIN_W-1:0]   window_reg   = WINDOW_RESET;

    logic [SUM_W-1:0] pending_sums [$];
    logic [SUM_W-1:0] want_sum;
    int               items_taken    = 0;
    int               faults         = 0;
    bit               calm           = 1'b0;
    bit               held_off       = 1'b0;

    stim_row_t        plan [N_ROWS];
    logic [WIN_W-1:0] window_plan [N_PHASES] =
        '{7'd64, 7'd10, 7'd0, 7'd127, 7'd37, 7'd9, 7'd65, 7'd64, 7'd11};

    function automatic void retire_oldest();
        if (held_cnt == 0)
            return;
        window_total = window_total - bucket_mem[oldest_idx];
        oldest_idx++;
        held_cnt--;
    endfunction

    function automatic void append_bucket(input logic [SUM_W-1:0] v);
        if (held_cnt >= WINDOW_DEPTH_DEF)
            retire_oldest();
        bucket_mem[6'(oldest_idx + held_cnt)] = v;
        held_cnt++;
    endfunction

    function automatic void count_trade();
        if (open_trades != '1)
            open_trades++;
    endfunction

    function automatic bit close_buckets(input logic [PAGES_W-1:0] pages,
                                         input logic [SECS_W-1:0] secs,
                                         output logic [SUM_W-1:0] sum_out);
        int unsigned w;
        int unsigned zeros;
        sum_out = '0;
        if (!minute_seen)
        begin
            if (secs % MINUTE_SECS != 0)
                return 1'b0;
            minute_seen = 1'b1;
        end
        w = window_reg;
        if (w < MIN_WINDOW)
            w = MIN_WINDOW;
        if (w > WINDOW_DEPTH_DEF)
            w = WINDOW_DEPTH_DEF;
        zeros = (pages == 0) ? 0 : pages - 1;
        if (zeros > w)
            zeros = w;
        for (int unsigned i = 0; i < zeros; i++)
        begin
            if (held_cnt + 1 >= w)
                retire_oldest();
            append_bucket('0);
        end
        while (held_cnt >= w)
            retire_oldest();
        append_bucket(open_trades);
        window_total = window_total + open_trades;
        open_trades  = '0;
        pages_acc    = pages_acc + pages;
        if (pages_acc >= EMIT_PAGES)
        begin
            pages_acc = '0;
            sum_out   = window_total;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_req(input req_type_t op, input logic [PAGES_W-1:0] pages,
                            input logic [SECS_W-1:0] secs, input bit typed,
                            input bit typed_fire, input logic [SUM_W-1:0] typed_sum);
        logic [SUM_W-1:0] s;
        bit               fires;
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= op;
        req_ch.pages_to_add <= pages;
        req_ch.time_seconds <= secs;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_taken++;
        fires = 1'b0;
        if (op == REQ_TRADE)
            count_trade();
        else
            fires = close_buckets(pages, secs, s);
        if (typed)
        begin
            fires = typed_fire;
            s     = typed_sum;
        end
        if (fires)
            pending_sums = {pending_sums, s};
        @(negedge clk);
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        cfg_we     <= 1'b1;
        cfg_wdata  <= w;
        @(negedge clk);
        cfg_we     <= 1'b0;
        window_reg  = w;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold-off
    initial
    begin
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && items_taken >= STALL_AFTER)
            begin
                res_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                held_off = 1'b1;
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: window_sum expected none, actual %0d",
                         $time, res_ch.window_sum);
                faults++;
            end
            else
            begin
                want_sum = pending_sums.pop_front();
                if (res_ch.window_sum !== want_sum)
                begin
                    $display("%0t: window_sum expected %0d, actual %0d",
                             $time, want_sum, res_ch.window_sum);
                    faults++;
                end
            end
        end
    end

    initial
    begin
        int                 n;
        logic [PAGES_W-1:0] pg;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_TRADE;
        req_ch.pages_to_add = '0;
        req_ch.time_seconds = '0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;

        plan = '{
            // ticks off the minute are ignored until the first aligned one
            '{REQ_TRADE, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'd0},
            '{REQ_TRADE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0},
            '{REQ_TICK,  16'd60,   32'd61,        1'b1, 1'b0, 32'd0},
            '{REQ_TICK,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd0},
            '{REQ_TICK,  16'd0,    32'd59,        1'b1, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd1,    32'd0,         1'b1, 1'b0, 32'd0},
            '{REQ_TICK,  16'd60,   32'd120,       1'b1, 1'b1, 32'd3},
            // zero pages: bucket closed, page count unchanged
            '{REQ_TICK,  16'd0,    32'd7,         1'b1, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd5,    32'd1,         1'b0, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd6,    32'd2,         1'b0, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd7,    32'd3,         1'b0, 1'b0, 32'd0},
            // long gap, clamped to the window
            '{REQ_TICK,  16'hFFFF, 32'd0,         1'b0, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd0,    32'd0,         1'b0, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd0,    32'd0,         1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'd1,    32'd30,        1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'd59,   32'd90,        1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'h8000, 32'h8000_0000, 1'b0, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd0,    32'd0,         1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'h7FFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'd12,   32'h5555_5555, 1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'd48,   32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0},
            '{REQ_TRADE, 16'd0,    32'd0,         1'b0, 1'b0, 32'd0},
            '{REQ_TICK,  16'd11,   32'd0,         1'b0, 1'b0, 32'd0}
        };

        wait (rst_n);
        @(negedge clk);

        for (int r = 0; r < N_ROWS; r++)
            push_req(plan[r].op, plan[r].pages, plan[r].secs, plan[r].typed,
                     plan[r].typed_fire, plan[r].typed_sum);
        quiesce();

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_window(window_plan[p]);
            calm = (p == 3);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 70)
                    push_req(REQ_TRADE, 16'($urandom), $urandom, 1'b0, 1'b0, '0);
                else
                begin
                    case ($urandom_range(0, 9))
                        0:       pg = '0;
                        1:       pg = 16'($urandom_range(0, 65535));
                        2, 3, 4,
                        5:       pg = 16'($urandom_range(1, 3));
                        default: pg = 16'($urandom_range(1, 20));
                    endcase
                    push_req(REQ_TICK, pg, $urandom, 1'b0, 1'b0, '0);
                end
                n++;
            end
            quiesce();
        end
        calm = 1'b0;

        if (faults == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
